/* hdl/stpb_pkg.sv */
// stpb_pkg: shared types and constants for the spanning-tree BPDU receive engine.
// No dependencies; used by every module under hdl.
package stpb_pkg;

	// number of local ports with a stored best BPDU (2 to 16; port numbers are 4 bits wide)
	localparam int NUM_PORTS = 16;
	localparam int PORT_W    = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

	localparam int ID_W   = 48;
	localparam int COST_W = 32;
	localparam int LINK_W = 16;
	localparam int PNUM_W = 4;

	// action codes of an input item
	localparam logic ACT_BPDU = 1'b0;
	localparam logic ACT_INIT = 1'b1;

	typedef logic [PORT_W-1:0] port_idx_t;

	// priority vector; root is most significant so a plain compare orders it
	typedef struct packed {
		logic [ID_W-1:0]   root;
		logic [COST_W-1:0] cost;
		logic [ID_W-1:0]   sender;
	} vec_t;

	// write/clear request from the sequencer to the port table
	typedef struct packed {
		logic      wr_en;
		port_idx_t wr_idx;
		vec_t      wr_data;
		logic      clr_all;
	} tbl_wr_t;

endpackage

/* hdl/stpb_vec_cmp.sv */
// stpb_vec_cmp: shared priority-vector comparator.
// Depends on stpb_pkg for vec_t.
module stpb_vec_cmp (
	input  stpb_pkg::vec_t a,
	input  stpb_pkg::vec_t b,
	output logic           better
);

	// lexicographic root, cost, sender order; equal is not better
	assign better = a < b;

endmodule

/* hdl/stpb_port_table.sv */
// stpb_port_table: per-port best BPDU memory with valid bits.
// Depends on stpb_pkg for vec_t, port_idx_t and tbl_wr_t.
module stpb_port_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  stpb_pkg::port_idx_t rd_idx,
	input  stpb_pkg::tbl_wr_t   wr,
	output stpb_pkg::vec_t      rd_data,
	output logic                rd_valid
);

	stpb_pkg::vec_t                   mem_q [stpb_pkg::NUM_PORTS];
	logic [stpb_pkg::NUM_PORTS-1:0]   valid_q;
	stpb_pkg::vec_t                   rd_data_q;
	logic                             rd_valid_q;

	// entry storage and registered read, no reset on payload
	always_ff @(posedge clk) begin
		if (wr.wr_en) begin
			mem_q[wr.wr_idx] <= wr.wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_idx];
		end
	end

	// valid bits: init clears all at once, a write sets one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr.clr_all) begin
				valid_q <= '0;
			end else if (wr.wr_en) begin
				valid_q[wr.wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_idx];
			end
		end
	end

	assign rd_data  = rd_data_q;
	assign rd_valid = rd_valid_q;

endmodule

/* hdl/stp_bpdu_receive.sv */
// stp_bpdu_receive: BPDU receive engine top level with sequencer and root state.
// Depends on stpb_pkg, stpb_vec_cmp and stpb_port_table.
// An accepted item runs the table-compare step, then the own-vector step, which registers done.
// Busy is high for the one table-compare cycle; a new item can be taken in the own-vector step.
// The single comparator is used twice per item: against the port entry, then the own vector.
// Reset: root = 0, cost 0, root port 0, own id 0, all port entries invalid; no stall on results.
module stp_bpdu_receive (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        action,
	input  logic [3:0]  in_port,
	input  logic [47:0] bpdu_root_id,
	input  logic [31:0] bpdu_cost,
	input  logic [47:0] bpdu_sender_id,
	input  logic [15:0] link_cost,
	input  logic        cfg_we,
	input  logic [47:0] cfg_data,
	output logic        done,
	output logic        changed,
	output logic [47:0] root_id,
	output logic [31:0] root_cost,
	output logic [3:0]  uplink_port,
	output logic        is_root,
	output logic        port_entry_updated
);

	localparam int PW = stpb_pkg::PORT_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PORT,
		S_OWN
	} state_t;

	state_t                       state_q;
	logic                         accept;
	logic [32:0]                  cost_sum;
	logic [31:0]                  cost_sat;
	logic                         port_ok;

	// item registers
	logic                         act_q;
	logic [3:0]                   port_q;
	logic                         port_ok_q;
	stpb_pkg::vec_t               rvec_q;

	// root state and result flags
	logic [47:0]                  own_id_q;
	logic [47:0]                  cur_root_q;
	logic [31:0]                  cur_cost_q;
	logic [3:0]                   cur_port_q;
	logic                         upd_q;
	logic                         done_q;
	logic                         changed_q;
	logic                         is_root_q;
	logic                         out_upd_q;

	stpb_pkg::vec_t               cmp_b;
	logic                         better;
	stpb_pkg::vec_t               tbl_rd_data;
	logic                         tbl_rd_valid;
	stpb_pkg::tbl_wr_t            tbl_wr;
	logic                         take_port;
	logic [47:0]                  nxt_root;

	assign busy   = (state_q == S_PORT);
	assign accept = start && !busy;

	// received cost plus link cost, saturating
	assign cost_sum = {1'b0, bpdu_cost} + {17'd0, link_cost};
	assign cost_sat = cost_sum[32] ? '1 : cost_sum[31:0];
	assign port_ok  = 32'(in_port) < stpb_pkg::NUM_PORTS;

	// capture the item at accept
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q       <= action;
			port_q      <= in_port;
			port_ok_q   <= port_ok;
			rvec_q      <= '{root: bpdu_root_id, cost: cost_sat, sender: bpdu_sender_id};
		end
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q <= '0;
		end else if (cfg_we) begin
			own_id_q <= cfg_data;
		end
	end

	// shared comparator: port entry first, own vector second
	assign cmp_b = (state_q == S_PORT) ? tbl_rd_data :
		stpb_pkg::vec_t'{root: cur_root_q, cost: cur_cost_q, sender: own_id_q};

	stpb_vec_cmp u_cmp (
		.a      (rvec_q),
		.b      (cmp_b),
		.better (better)
	);

	// table write, or table clear on init, in the port-compare step
	always_comb begin
		take_port      = (act_q == stpb_pkg::ACT_BPDU) && port_ok_q
			&& (!tbl_rd_valid || better);
		tbl_wr.wr_en   = (state_q == S_PORT) && take_port;
		tbl_wr.wr_idx  = PW'(port_q);
		tbl_wr.wr_data = rvec_q;
		tbl_wr.clr_all = (state_q == S_PORT) && (act_q == stpb_pkg::ACT_INIT);
	end

	stpb_port_table u_tbl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_idx   (PW'(in_port)),
		.wr       (tbl_wr),
		.rd_data  (tbl_rd_data),
		.rd_valid (tbl_rd_valid)
	);

	// root after the own-vector step, for the is_root flag
	always_comb begin
		if (act_q == stpb_pkg::ACT_INIT) begin
			nxt_root = own_id_q;
		end else if (better) begin
			nxt_root = rvec_q.root;
		end else begin
			nxt_root = cur_root_q;
		end
	end

	// sequencer, root state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cur_root_q <= '0;
			cur_cost_q <= '0;
			cur_port_q <= '0;
			upd_q      <= 1'b0;
			done_q     <= 1'b0;
			changed_q  <= 1'b0;
			is_root_q  <= 1'b0;
			out_upd_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_PORT;
					end
				end
				S_PORT: begin
					upd_q   <= take_port;
					state_q <= S_OWN;
				end
				S_OWN: begin
					done_q    <= 1'b1;
					out_upd_q <= upd_q;
					is_root_q <= (nxt_root == own_id_q);
					if (act_q == stpb_pkg::ACT_INIT) begin
						cur_root_q <= own_id_q;
						cur_cost_q <= '0;
						cur_port_q <= '0;
						changed_q  <= 1'b0;
					end else if (better) begin
						cur_root_q <= rvec_q.root;
						cur_cost_q <= rvec_q.cost;
						if (port_ok_q) begin
							cur_port_q <= port_q;
						end
						changed_q  <= 1'b1;
					end else begin
						changed_q  <= 1'b0;
					end
					state_q <= accept ? S_PORT : S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done               = done_q;
	assign changed            = changed_q;
	assign root_id            = cur_root_q;
	assign root_cost          = cur_cost_q;
	assign uplink_port        = cur_port_q;
	assign is_root            = is_root_q;
	assign port_entry_updated = out_upd_q;

	// an accepted item always enters the table-compare step
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not start the table compare");

	// a result strobe follows a table-compare step, with the own-vector step between them
	a_done_after_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy, 2))
		else $error("result strobe without a preceding compare step");

	// is_root agrees with the reported root and the own id
	a_is_root: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_root == (root_id == own_id_q)))
		else $error("is_root disagrees with root_id");

endmodule
